// ----- hdl/wmms_pkg.sv -----
// shared types and constants for the windowed min/max/mean statistics block
package wmms_pkg;

    localparam int DATA_W         = 16;
    localparam int TIME_W         = 32;
    localparam int SUM_W          = 32;
    localparam int OUT_COUNT_W    = 16;
    localparam int CHAN_W         = 2;
    localparam int INPUT_LANES    = 4;
    localparam int COUNT_BITS_DEF = 16;
    localparam int CHANNELS_DEF   = 4;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [TIME_W-1:0]        time_t;

    localparam data_t DATA_MAX = data_t'(16'sh7fff);
    localparam data_t DATA_MIN = data_t'(16'sh8000);
    localparam sum_t  SUM_MAX  = sum_t'(32'sh7fffffff);
    localparam sum_t  SUM_MIN  = sum_t'(32'sh80000000);

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLOSE  = 1'b1;

endpackage

// ----- hdl/wmms_lane.sv -----
// per-channel accumulator: running minimum, maximum, saturating sum and count
module wmms_lane #(
    parameter int COUNT_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    upd,
    input  logic                    clr,
    input  wmms_pkg::data_t         value,
    input  logic                    ok,
    output wmms_pkg::data_t         min_value,
    output wmms_pkg::data_t         max_value,
    output wmms_pkg::sum_t          sum,
    output logic [COUNT_BITS-1:0]   count
);
    import wmms_pkg::*;

    data_t                 min_reg, min_next;
    data_t                 max_reg, max_next;
    sum_t                  sum_reg, sum_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [SUM_W:0]        sum_wide;

    always_comb
    begin
        min_next   = min_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        count_next = count_reg;
        sum_wide   = {sum_reg[SUM_W-1], sum_reg} + {{(SUM_W+1-DATA_W){value[DATA_W-1]}}, value};
        if (clr)
        begin
            min_next   = DATA_MAX;
            max_next   = DATA_MIN;
            sum_next   = '0;
            count_next = '0;
        end
        else if (upd && ok)
        begin
            if (value < min_reg)
                min_next = value;
            if (value > max_reg)
                max_next = value;
            // a saturated count freezes the sum so the mean stays consistent
            if (count_reg != '1)
            begin
                count_next = count_reg + 1'b1;
                if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                    sum_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
                else
                    sum_next = sum_t'(sum_wide[SUM_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= DATA_MAX;
            max_reg   <= DATA_MIN;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            min_reg   <= min_next;
            max_reg   <= max_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    assign min_value = min_reg;
    assign max_value = max_reg;
    assign sum       = sum_reg;
    assign count     = count_reg;

endmodule

// ----- hdl/wmms_div.sv -----
// bit-serial restoring divider, one quotient bit per cycle
module wmms_div #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);
    import wmms_pkg::*;

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
                quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hdl/windowed_min_max_avg_stats.sv -----
// top level: four-channel windowed minimum / maximum / mean statistics
// A sample request (cmd 0) is taken back to back and updates the
// per-channel lanes in parallel. A close request (cmd 1) on an open window holds
// the input stalled while one result per channel is produced in channel order:
// each channel's mean comes from one shared bit-serial divider at one quotient
// bit per cycle. A close on an empty window produces nothing. After the last
// result (last = 1) is taken the window is cleared and samples resume.
module windowed_min_max_avg_stats #(
    parameter int COUNT_BITS = wmms_pkg::COUNT_BITS_DEF,
    parameter int CHANNELS   = wmms_pkg::CHANNELS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  cmd,
    input  wmms_pkg::time_t       timestamp,
    input  wmms_pkg::data_t       probe_temp,
    input  logic                  probe_temp_ok,
    input  wmms_pkg::data_t       air_temp,
    input  logic                  air_temp_ok,
    input  wmms_pkg::data_t       humidity,
    input  logic                  humidity_ok,
    input  wmms_pkg::data_t       soil_raw,
    input  logic                  soil_raw_ok,
    output logic                  out_valid,
    input  logic                  out_stall,
    output wmms_pkg::time_t       start_time,
    output wmms_pkg::time_t       end_time,
    output logic [wmms_pkg::OUT_COUNT_W-1:0] window_count,
    output logic [wmms_pkg::CHAN_W-1:0]      channel,
    output logic                  stat_valid,
    output wmms_pkg::data_t       mean_value,
    output wmms_pkg::data_t       min_value,
    output wmms_pkg::data_t       max_value,
    output logic                  last
);
    import wmms_pkg::*;

    localparam int LANES = (CHANNELS < INPUT_LANES) ? CHANNELS : INPUT_LANES;
    localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_DIV = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [IDX_W-1:0]      chan_reg, chan_next;
    logic                  win_open_reg, win_open_next;
    time_t                 win_start_reg, win_start_next;
    time_t                 win_end_reg, win_end_next;
    logic [COUNT_BITS-1:0] win_samples_reg, win_samples_next;
    data_t                 mean_reg, mean_next;
    logic                  neg_reg, neg_next;

    data_t                 in_vals [INPUT_LANES];
    logic                  in_oks  [INPUT_LANES];
    data_t                 lane_min [LANES];
    data_t                 lane_max [LANES];
    sum_t                  lane_sum [LANES];
    logic [COUNT_BITS-1:0] lane_count [LANES];

    logic                  in_acc;
    logic                  out_acc;
    logic                  sample_acc;
    logic                  close_start;
    logic                  is_last;
    logic                  lane_clr;
    logic                  div_start;
    logic                  div_done;
    logic [IDX_W-1:0]      div_idx;
    sum_t                  div_sum;
    logic [SUM_W-1:0]      div_mag;
    logic [SUM_W-1:0]      div_quo;
    logic                  chan_ok;

    assign in_vals[0] = probe_temp;
    assign in_vals[1] = air_temp;
    assign in_vals[2] = humidity;
    assign in_vals[3] = soil_raw;
    assign in_oks[0]  = probe_temp_ok;
    assign in_oks[1]  = air_temp_ok;
    assign in_oks[2]  = humidity_ok;
    assign in_oks[3]  = soil_raw_ok;

    assign in_stall    = (state_reg != ST_RUN);
    assign out_valid   = (state_reg == ST_OUT);
    assign in_acc      = in_valid && !in_stall;
    assign out_acc     = out_valid && !out_stall;
    assign sample_acc  = in_acc && (cmd == CMD_SAMPLE);
    assign close_start = in_acc && (cmd == CMD_CLOSE) && win_open_reg;
    assign is_last     = (chan_reg == IDX_W'(LANES - 1));
    assign lane_clr    = out_acc && is_last;

    genvar g;
    generate
        for (g = 0; g < LANES; g++)
        begin : g_lane
            wmms_lane #(
                .COUNT_BITS (COUNT_BITS)
            ) u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .upd       (sample_acc),
                .clr       (lane_clr),
                .value     (in_vals[g]),
                .ok        (in_oks[g]),
                .min_value (lane_min[g]),
                .max_value (lane_max[g]),
                .sum       (lane_sum[g]),
                .count     (lane_count[g])
            );
        end
    endgenerate

    // divide the magnitude of the sum, sign is restored afterwards
    assign div_start = close_start || (out_acc && !is_last);
    assign div_idx   = close_start ? '0 : chan_reg + 1'b1;
    assign div_sum   = lane_sum[div_idx];
    assign div_mag   = div_sum[SUM_W-1] ? (~div_sum + 1'b1) : div_sum;

    wmms_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_mag),
        .divisor  (lane_count[div_idx]),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign chan_ok = (lane_count[chan_reg] != '0);

    always_comb
    begin
        state_next       = state_reg;
        chan_next        = chan_reg;
        win_open_next    = win_open_reg;
        win_start_next   = win_start_reg;
        win_end_next     = win_end_reg;
        win_samples_next = win_samples_reg;
        mean_next        = mean_reg;
        neg_next         = neg_reg;
        if (div_start)
            neg_next = div_sum[SUM_W-1];
        unique case (state_reg)
            ST_RUN:
            begin
                if (sample_acc)
                begin
                    if (!win_open_reg)
                    begin
                        win_start_next = timestamp;
                        win_open_next  = 1'b1;
                    end
                    win_end_next = timestamp;
                    if (win_samples_reg != '1)
                        win_samples_next = win_samples_reg + 1'b1;
                end
                else if (close_start)
                begin
                    chan_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (!chan_ok)
                        mean_next = '0;
                    else if (neg_reg)
                        mean_next = (div_quo > SUM_W'(32768)) ? DATA_MIN
                                                              : data_t'(~div_quo + 1'b1);
                    else
                        mean_next = (div_quo > SUM_W'(32767)) ? DATA_MAX
                                                              : data_t'(div_quo[DATA_W-1:0]);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_acc)
                begin
                    if (is_last)
                    begin
                        win_open_next    = 1'b0;
                        win_start_next   = '0;
                        win_end_next     = '0;
                        win_samples_next = '0;
                        state_next       = ST_RUN;
                    end
                    else
                    begin
                        chan_next  = chan_reg + 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_RUN;
            chan_reg        <= '0;
            win_open_reg    <= 1'b0;
            win_start_reg   <= '0;
            win_end_reg     <= '0;
            win_samples_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            chan_reg        <= chan_next;
            win_open_reg    <= win_open_next;
            win_start_reg   <= win_start_next;
            win_end_reg     <= win_end_next;
            win_samples_reg <= win_samples_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg <= mean_next;
        neg_reg  <= neg_next;
    end

    generate
        if (COUNT_BITS > OUT_COUNT_W)
        begin : g_cnt_clamp
            assign window_count = (|win_samples_reg[COUNT_BITS-1:OUT_COUNT_W])
                                  ? '1 : win_samples_reg[OUT_COUNT_W-1:0];
        end
        else
        begin : g_cnt_ext
            assign window_count = OUT_COUNT_W'(win_samples_reg);
        end
    endgenerate

    assign start_time = win_start_reg;
    assign end_time   = win_end_reg;
    assign channel    = CHAN_W'(chan_reg);
    assign stat_valid = chan_ok;
    assign mean_value = mean_reg;
    assign min_value  = chan_ok ? lane_min[chan_reg] : '0;
    assign max_value  = chan_ok ? lane_max[chan_reg] : '0;
    assign last       = is_last;

endmodule
